### rtl/rotated_bitmap_text_renderer_defines.svh
// Assertion macros shared by the renderer RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ROTATED_BITMAP_TEXT_RENDERER_DEFINES_SVH
`define ROTATED_BITMAP_TEXT_RENDERER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RBTR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RBTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rbtr_pkg.sv
// Shared types, constants and the 5x7 glyph table of the bitmap text renderer.
// No dependencies; every RTL module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rbtr_pkg;

  localparam int PANEL_WIDTH_DEF  = 80;
  localparam int PANEL_HEIGHT_DEF = 128;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;

  localparam logic [7:0] PIX_MSB   = 8'h80;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam int         CFG_ADDR_W     = 3;
  localparam logic       CFG_ROTATE_IDX = 1'b0;
  localparam logic [1:0] ROTATE_RESET   = 2'd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_CHAR  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Column-major glyph: element 0 is the left column, bit 0 the top row.
  typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

  // Result of the pixel address unit, apart from the byte address itself.
  typedef struct packed {
    logic       hit;
    logic       white;
    logic [7:0] mask;
  } pix_ctl_t;

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h30:   g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'h31:   g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32:   g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33:   g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34:   g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35:   g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36:   g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37:   g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39:   g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      8'h43:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      8'h4D:   g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h54:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h65:   g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      8'h6D:   g = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      8'h70:   g = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
      8'h3A:   g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      8'h2E:   g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      8'h2D:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      default: g = '0;  // Space and every code without a glyph are blank.
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### rtl/rotated_bitmap_text_renderer.sv
// A pixel draw passes ST_CALC, ST_RD and ST_WR, skipping ST_WR when the pixel is clipped;
// a character repeats that walk for each glyph pixel; a byte read passes ST_RDREQ and
// ST_RDOUT; a clear writes every store byte in turn.
// One command at a time; each pixel is a read-modify-write over the single store port.
// Reset (rst, synchronous, active high) idles the sequencer and sets rotate_mode to 1;
// the frame store is not cleared. The done beat cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_bitmap_text_renderer_defines.svh"

module rotated_bitmap_text_renderer
  import rbtr_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready,
  // Command channel
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [1:0]            operation,
  input  wire logic [7:0]            pos_x,
  input  wire logic [7:0]            pos_y,
  input  wire logic                  pixel_color,
  input  wire logic [7:0]            char_code,
  input  wire logic [10:0]           byte_index,
  // Result channel
  output      logic                  done,
  output      logic [7:0]            read_data
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  // Wide enough to hold both byte_index and the store size for the range check.
  localparam int CMP_W       = (ADDR_W > 11) ? ADDR_W + 1 : 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CALC,
    ST_RD,
    ST_WR,
    ST_RDREQ,
    ST_RDOUT
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration register. Only rotate_mode exists; the word at index 1 is
  // reserved, reads as zero and ignores writes.
  // ---------------------------------------------------------------------------
  logic [1:0] rotate_mode;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_mode <= ROTATE_RESET;
    end else if (cfg_write && (paddr[2] == CFG_ROTATE_IDX)) begin
      rotate_mode <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_ROTATE_IDX) ? {30'd0, rotate_mode} : 32'd0;

  // ---------------------------------------------------------------------------
  // Command sequencer state.
  // ---------------------------------------------------------------------------
  state_t            state;
  op_t               op_q;
  logic [7:0]        base_x;
  logic [7:0]        base_y;
  logic              color_q;
  glyph_t            glyph_q;
  logic [10:0]       idx_q;
  logic              idx_ok_q;
  logic [2:0]        col;
  logic [2:0]        row;
  logic [ADDR_W-1:0] clr_addr;

  logic              accept;
  logic              idx_ok;
  logic              last_pixel;

  // Pixel unit and memory signals.
  logic [8:0]        pix_x;
  logic [8:0]        pix_y;
  logic              pix_white;
  logic [ADDR_W-1:0] pu_addr;
  pix_ctl_t          pu_ctl;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign idx_ok = CMP_W'(byte_index) < CMP_W'(STORE_BYTES);

  // A character is walked column by column, seven rows per column; a single
  // pixel command is the same walk cut short after its first point.
  assign last_pixel = (op_q != OP_CHAR) ||
                      ((col == 3'(GLYPH_COLS - 1)) && (row == 3'(GLYPH_ROWS - 1)));

  // The glyph bit marks ink, which is drawn black.
  assign pix_x     = {1'b0, base_x} + {6'd0, col};
  assign pix_y     = {1'b0, base_y} + {6'd0, row};
  assign pix_white = (op_q == OP_CHAR) ? !glyph_q[col][row] : color_q;

  rbtr_pixel_unit #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_pixel_unit (
    .clk       (clk),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_white (pix_white),
    .rot       (rotate_mode),
    .addr      (pu_addr),
    .ctl       (pu_ctl)
  );

  // The store port is shared between the clear sweep, the pixel read-modify-write
  // and the byte read; only one of them owns it in any state.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pu_addr;
    mem_wdata = FILL_BYTE;
    unique case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_RD: begin
        mem_re = pu_ctl.hit;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_wdata = pu_ctl.white ? (mem_rdata | pu_ctl.mask) : (mem_rdata & ~pu_ctl.mask);
      end
      ST_RDREQ: begin
        mem_re   = idx_ok_q;
        mem_addr = ADDR_W'(idx_q);
      end
      ST_IDLE, ST_CALC, ST_RDOUT: begin
      end
      default: begin
      end
    endcase
  end

  rbtr_frame_mem #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_frame_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Sequencer: one command per pass, done pulses for one cycle on return to idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      col      <= '0;
      row      <= '0;
      clr_addr <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= op_t'(operation);
            base_x   <= pos_x;
            base_y   <= pos_y;
            color_q  <= pixel_color;
            glyph_q  <= glyph_lookup(char_code);
            idx_q    <= byte_index;
            idx_ok_q <= idx_ok;
            col      <= '0;
            row      <= '0;
            clr_addr <= '0;
            unique case (op_t'(operation))
              OP_CLEAR: state <= ST_CLEAR;
              OP_PIXEL: state <= ST_CALC;
              OP_CHAR:  state <= ST_CALC;
              OP_READ:  state <= ST_RDREQ;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
            state     <= ST_IDLE;
            done      <= 1'b1;
            read_data <= '0;
          end
        end
        ST_CALC: begin
          state <= ST_RD;
        end
        ST_RD, ST_WR: begin
          if ((state == ST_RD) && pu_ctl.hit) begin
            state <= ST_WR;
          end else if (last_pixel) begin
            state     <= ST_IDLE;
            done      <= 1'b1;
            read_data <= '0;
          end else begin
            state <= ST_CALC;
            if (row == 3'(GLYPH_ROWS - 1)) begin
              row <= '0;
              col <= col + 3'd1;
            end else begin
              row <= row + 3'd1;
            end
          end
        end
        ST_RDREQ: begin
          state <= ST_RDOUT;
        end
        ST_RDOUT: begin
          state     <= ST_IDLE;
          done      <= 1'b1;
          read_data <= idx_ok_q ? mem_rdata : 8'd0;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checks on the sequencer.
  // ---------------------------------------------------------------------------
  `RBTR_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
  `RBTR_ASSERT_IMPLIES(a_done_idle, done, !busy, "done beat while the sequencer is busy")
  `RBTR_ASSERT_IMPLIES(a_done_zero, done && (op_q != OP_READ), read_data == 8'd0,
                       "non-read command returned nonzero data")
  `RBTR_ASSERT_IMPLIES(a_write_hit, mem_we && (state != ST_CLEAR), pu_ctl.hit,
                       "pixel write to a clipped location")
  `RBTR_ASSERT_IMPLIES(a_port_excl, mem_we, !mem_re, "store read and write in one cycle")

endmodule

`default_nettype wire

### rtl/rbtr_pixel_unit.sv
// Shared pixel address unit: clip, rotate and map one logical pixel to a store byte.
// Depends on rbtr_pkg. Results are registered.
`timescale 1ns / 1ps
`default_nettype none

module rbtr_pixel_unit
  import rbtr_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int ADDR_W       = 11
) (
  input  wire logic              clk,
  input  wire logic [8:0]        pix_x,
  input  wire logic [8:0]        pix_y,
  input  wire logic              pix_white,
  input  wire logic [1:0]        rot,
  output      logic [ADDR_W-1:0] addr,
  output      pix_ctl_t          ctl
);

  localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
  localparam int PROD_W    = 14;

  logic              on_panel;
  logic [7:0]        px;
  logic [7:0]        py;
  logic [PROD_W-1:0] row_base;
  logic [ADDR_W-1:0] addr_next;

  always_comb begin
    on_panel = (pix_x < 9'(PANEL_HEIGHT)) && (pix_y < 9'(PANEL_WIDTH));
    px = rot[0] ? 8'(PANEL_WIDTH - 1) - pix_y[7:0] : pix_y[7:0];
    py = rot[1] ? 8'(PANEL_HEIGHT - 1) - pix_x[7:0] : pix_x[7:0];
    row_base  = PROD_W'(py) * PROD_W'(ROW_BYTES);
    addr_next = ADDR_W'(row_base + PROD_W'(px[7:3]));
  end

  always_ff @(posedge clk) begin
    addr      <= addr_next;
    ctl.hit   <= on_panel;
    ctl.white <= pix_white;
    ctl.mask  <= PIX_MSB >> px[2:0];
  end

endmodule

`default_nettype wire

### rtl/rbtr_frame_mem.sv
// Single-port byte-wide frame store with registered read data.
// Depends on rbtr_pkg for the default panel size behind DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module rbtr_frame_mem
  import rbtr_pkg::*;
#(
  parameter int DEPTH  = PANEL_HEIGHT_DEF * ((PANEL_WIDTH_DEF + 7) / 8),
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [7:0]        wdata,
  output      logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rotated_bitmap_text_renderer: clear, pixel, character and read
// commands are checked against a frame store predictor kept inside this module.
// Depends on rbtr_pkg and the renderer RTL only.

module tb_top;
  import rbtr_pkg::*;

  // Panel geometry follows the defaults that the block is built with.
  localparam int PANEL_W     = PANEL_WIDTH_DEF;
  localparam int PANEL_H     = PANEL_HEIGHT_DEF;
  localparam int ROW_BYTES   = (PANEL_W + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_H;

  localparam logic [CFG_ADDR_W-1:0] ROTATE_ADDR = CFG_ADDR_W'(4 * CFG_ROTATE_IDX);

  // The slowest command is a clear, and a sender gap can add to it; the limit sits
  // several times above what some 550 commands that were all clears, each after the
  // longest gap, would need.
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TOUCHED_DEPTH = 32;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [1:0]            operation   = OP_CLEAR;
  logic [7:0]            pos_x       = '0;
  logic [7:0]            pos_y       = '0;
  logic                  pixel_color = 1'b0;
  logic [7:0]            char_code   = '0;
  logic [10:0]           byte_index  = '0;
  logic                  done;
  logic [7:0]            read_data;

  rotated_bitmap_text_renderer dut (.*);

  always #1 clk = ~clk;

  // One command as the sender sees it. Every field is driven on every beat, whatever
  // the operation, so that the block is seen to ignore the ones it does not use.
  typedef struct {
    op_t         op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        color;
    logic [7:0]  code;
    logic [10:0] idx;
  } render_cmd_t;

  // What the done beat of one accepted command must carry.
  typedef struct {
    op_t        op;
    logic [7:0] data;
  } read_beat_t;

  read_beat_t  expected_beats[$];

  // Shadow of the frame store and of the orientation register. The first command
  // after reset is a clear, so no byte is ever read before it has been written.
  logic [7:0]  shadow_frame [STORE_BYTES];
  logic [1:0]  shadow_rotate = ROTATE_RESET;

  // Byte addresses that recent draws wrote; reads aim at them most of the time,
  // since a draw is only observed through a later read.
  int unsigned touched_addr[$];

  int          error_count = 0;
  int          cycle_count = 0;
  int          idle_pct    = 0;

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // The 5x7 font, packed left column first; within a column bit 0 is the top row.
  // Space and every code without a glyph come out blank.
  function automatic logic [39:0] font_bits(input logic [7:0] code);
    case (code)
      8'h30:   return 40'h3E_51_49_45_3E;  // '0'
      8'h31:   return 40'h00_42_7F_40_00;  // '1'
      8'h32:   return 40'h42_61_51_49_46;  // '2'
      8'h33:   return 40'h21_41_45_4B_31;  // '3'
      8'h34:   return 40'h18_14_12_7F_10;  // '4'
      8'h35:   return 40'h27_45_45_45_39;  // '5'
      8'h36:   return 40'h3C_4A_49_49_30;  // '6'
      8'h37:   return 40'h01_71_09_05_03;  // '7'
      8'h38:   return 40'h36_49_49_49_36;  // '8'
      8'h39:   return 40'h06_49_49_29_1E;  // '9'
      8'h43:   return 40'h3E_41_41_41_22;  // 'C'
      8'h4D:   return 40'h7F_02_0C_02_7F;  // 'M'
      8'h54:   return 40'h01_01_7F_01_01;  // 'T'
      8'h55:   return 40'h3F_40_40_40_3F;  // 'U'
      8'h65:   return 40'h38_54_54_54_18;  // 'e'
      8'h6D:   return 40'h7C_04_18_04_78;  // 'm'
      8'h70:   return 40'h7C_14_14_14_08;  // 'p'
      8'h3A:   return 40'h00_36_36_00_00;  // ':'
      8'h2E:   return 40'h00_60_60_00_00;  // '.'
      8'h2D:   return 40'h08_08_08_08_08;  // '-'
      default: return '0;
    endcase
  endfunction

  // Sets or clears one logical pixel in the shadow store. Logical x runs along the
  // panel height and logical y along its width; anything off the panel is dropped.
  task automatic plot_pixel(input int x, input int y, input logic white);
    int         px;
    int         py;
    int         addr;
    logic [7:0] mask;
    if (x >= PANEL_H || y >= PANEL_W) return;
    px   = shadow_rotate[0] ? PANEL_W - 1 - y : y;
    py   = shadow_rotate[1] ? PANEL_H - 1 - x : x;
    addr = py * ROW_BYTES + px / 8;
    mask = PIX_MSB >> (px % 8);
    if (white) shadow_frame[addr] = shadow_frame[addr] | mask;
    else       shadow_frame[addr] = shadow_frame[addr] & ~mask;
    touched_addr.push_back(addr);
    if (touched_addr.size() > TOUCHED_DEPTH) void'(touched_addr.pop_front());
  endtask

  // Applies one accepted command to the shadow state and gives the byte that its
  // done beat must carry: the store byte for a read, zero for everything else.
  task automatic predict_read_data(input render_cmd_t c, output logic [7:0] data);
    logic [39:0] bits;
    data = '0;
    case (c.op)
      OP_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = FILL_BYTE;
      OP_PIXEL: plot_pixel(int'(c.x), int'(c.y), c.color);
      OP_CHAR: begin
        bits = font_bits(c.code);
        // Character pixels are placed without wrapping, so a glyph near the edge
        // of the coordinate range runs off the panel rather than around it.
        for (int col = 0; col < GLYPH_COLS; col++) begin
          for (int row = 0; row < GLYPH_ROWS; row++) begin
            plot_pixel(int'(c.x) + col, int'(c.y) + row, !bits[32 - 8 * col + row]);
          end
        end
      end
      OP_READ: if (c.idx < STORE_BYTES) data = shadow_frame[c.idx];
    endcase
  endtask

  // Sends one command beat. It is called just after a rising edge. Depending on the
  // idle setting the sender may first drop start for a while; such gaps land anywhere
  // inside the previous command's run. Otherwise start stays high straight from the
  // previous beat, so the next command waits on busy.
  task automatic send_command(input render_cmd_t c);
    logic [7:0] data;
    read_beat_t beat;
    int         gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(1, 120);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= c.op;
    pos_x       <= c.x;
    pos_y       <= c.y;
    pixel_color <= c.color;
    char_code   <= c.code;
    byte_index  <= c.idx;
    // The beat is taken at the first edge that sees start high and busy low.
    do @(posedge clk); while (busy !== 1'b0);
    predict_read_data(c, data);
    beat.op   = c.op;
    beat.data = data;
    expected_beats.push_back(beat);
  endtask

  // Drops start and waits until every outstanding done beat has come back. The wait
  // always passes a clock edge, so start is never lowered and raised in the same step.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  // One APB transfer to the orientation register: setup cycle, then access cycle
  // until pready. psel and penable then drop, so the next transfer starts cleanly.
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ROTATE_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_rotate_readback();
    logic [31:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[1:0] !== shadow_rotate)
      flag_mismatch($sformatf("rotate_mode reads %0d, expected %0d", rdata[1:0],
                              shadow_rotate));
  endtask

  // Changes the orientation only while the block is idle: all results in, busy low.
  // The upper data bits are random; only the low two bits are defined.
  task automatic set_rotation(input logic [1:0] mode);
    logic [31:0] unused_rdata;
    drain_results();
    while (busy !== 1'b0) @(posedge clk);
    apb_access(1'b1, {30'($urandom_range(32'h3FFF_FFFF)), mode}, unused_rdata);
    shadow_rotate = mode;
    check_rotate_readback();
  endtask

  function automatic render_cmd_t make_cmd(input op_t op, input int x, input int y,
                                           input logic color, input int code,
                                           input int idx);
    render_cmd_t c;
    c.op    = op;
    c.x     = x[7:0];
    c.y     = y[7:0];
    c.color = color;
    c.code  = code[7:0];
    c.idx   = idx[10:0];
    return c;
  endfunction

  // Random command mix. Most coordinates fall on or just past the panel, the rest
  // anywhere in range. Most characters have a glyph, and most reads hit a byte that a
  // recent draw wrote. Clears are rare since each one walks the whole store.
  function automatic render_cmd_t random_command();
    render_cmd_t c;
    int          pick;
    c.x     = 8'($urandom);
    c.y     = 8'($urandom);
    c.color = 1'($urandom);
    c.code  = 8'($urandom);
    c.idx   = 11'($urandom);
    pick    = $urandom_range(99);
    if (pick < 2) begin
      c.op = OP_CLEAR;
    end else if (pick < 62) begin
      c.op = (pick < 37) ? OP_PIXEL : OP_CHAR;
      if ($urandom_range(9) < 7) begin
        c.x = 8'($urandom_range(PANEL_H + 3));
        c.y = 8'($urandom_range(PANEL_W + 3));
      end
      if (c.op == OP_CHAR && $urandom_range(9) < 7) begin
        do c.code = 8'($urandom); while (font_bits(c.code) == '0 && c.code != 8'h20);
      end
    end else begin
      c.op = OP_READ;
      pick = $urandom_range(99);
      if (pick < 65 && touched_addr.size() != 0)
        c.idx = 11'(touched_addr[$urandom_range(touched_addr.size() - 1)]);
      else if (pick < 90)
        c.idx = 11'($urandom_range(STORE_BYTES - 1));
    end
    return c;
  endfunction

  // Reads back the byte that the latest draw wrote.
  task automatic probe_touched();
    int idx;
    idx = (touched_addr.size() != 0) ? touched_addr[$] : 0;
    send_command(make_cmd(OP_READ, $urandom, $urandom, 1'($urandom), $urandom, idx));
  endtask

  // The orientation register must come out of reset in the mirror-x setting.
  task automatic test_register_reset();
    check_rotate_readback();
  endtask

  // Short directed run in the reset orientation: edge addresses, reads past the end
  // of the store, pixels at the panel corners and just off it, a glyph, an unknown
  // code over it, a glyph cut by the panel edge and one entirely off it.
  task automatic test_directed();
    idle_pct = 0;
    send_command(make_cmd(OP_CLEAR, 0, 0, 1'b0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 0, 1'b0, 0, STORE_BYTES - 1));
    send_command(make_cmd(OP_READ, 0, 0, 1'b0, 0, STORE_BYTES));
    send_command(make_cmd(OP_READ, 255, 255, 1'b1, 255, 2047));
    send_command(make_cmd(OP_PIXEL, 0, 0, 1'b0, 0, 0));
    probe_touched();
    send_command(make_cmd(OP_PIXEL, PANEL_H - 1, PANEL_W - 1, 1'b0, 0, 0));
    probe_touched();
    send_command(make_cmd(OP_PIXEL, PANEL_H - 1, PANEL_W - 1, 1'b1, 0, 0));
    probe_touched();
    // Off the panel in x, in y and at the top of both ranges: nothing may change,
    // and a wrapped address would show up in the first row.
    send_command(make_cmd(OP_PIXEL, PANEL_H, 5, 1'b0, 0, 0));
    send_command(make_cmd(OP_PIXEL, 3, PANEL_W, 1'b0, 0, 0));
    send_command(make_cmd(OP_PIXEL, 255, 255, 1'b0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 0, 1'b0, 0, ROW_BYTES - 1));
    send_command(make_cmd(OP_CHAR, 0, 0, 1'b0, 8'h30, 0));
    probe_touched();
    send_command(make_cmd(OP_CHAR, 10, 10, 1'b1, 8'h4D, 0));
    probe_touched();
    send_command(make_cmd(OP_CHAR, 0, 0, 1'b0, 8'hFF, 0));
    probe_touched();
    send_command(make_cmd(OP_CHAR, PANEL_H - 3, PANEL_W - 3, 1'b0, 8'h3A, 0));
    probe_touched();
    send_command(make_cmd(OP_CHAR, 254, 254, 1'b0, 8'h38, 0));
    send_command(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0));
  endtask

  // Random traffic under one orientation and one sender idle rate. Now and then the
  // sender holds off until every expected beat is back, so the block goes fully idle
  // between two commands.
  task automatic test_random_traffic(input logic [1:0] mode, input int pct,
                                     input int count);
    set_rotation(mode);
    idle_pct = pct;
    repeat (count) begin
      if ($urandom_range(39) == 0) drain_results();
      send_command(random_command());
    end
  endtask

  // Result checker: every done beat is matched against the oldest expectation.
  // The receiver cannot stall, so each beat lasts exactly one cycle.
  always @(posedge clk) begin : check_results
    read_beat_t oldest;
    if (!rst) begin
      if ($isunknown(done)) begin
        flag_mismatch("done is unknown");
      end else if (done) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch($sformatf("done beat with nothing expected, read_data %02h",
                                  read_data));
        end else begin
          oldest = expected_beats.pop_front();
          if (read_data !== oldest.data)
            flag_mismatch($sformatf("%s: read_data %02h, expected %02h",
                                    oldest.op.name(), read_data, oldest.data));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               expected_beats.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed();
    // Orientation sweep, extremes first, with the sender idle rates in turn:
    // none at all, heavy, moderate, heavy again.
    test_random_traffic(2'd0, 0, 125);
    test_random_traffic(2'd3, 45, 125);
    test_random_traffic(2'd2, 27, 125);
    test_random_traffic(2'd1, 45, 125);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
